// File: rtl/sacl_pkg.sv
`default_nettype none

package sacl_pkg;

    // Fixed field widths of the stream items
    localparam int ADDR_W  = 32;
    localparam int OP_W    = 2;
    localparam int TAG_W   = 30;
    localparam int FETCH_W = 6;
    localparam int CB_W    = 20;
    localparam int OUT_W   = 48;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 4;

    // Parameter defaults
    localparam int DEF_MAX_SETS  = 1024;
    localparam int DEF_MAX_WAYS  = 8;
    localparam int DEF_ADDR_BITS = 32;

    // Access kinds
    localparam logic [OP_W-1:0] OP_ILOAD = 2'd0;
    localparam logic [OP_W-1:0] OP_DLOAD = 2'd1;
    localparam logic [OP_W-1:0] OP_STORE = 2'd2;
    localparam logic [OP_W-1:0] OP_FLUSH = 2'd3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SPLIT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WB    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WA    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BLK   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SETS0 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SETS1 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS  = 3'd6;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;      // latch item, read its set
        logic lookup;      // update set, load result
        logic scan_init;   // flush walk start
        logic scan_step;   // flush walk: read one set
        logic scan_out;    // load flush result
        logic clear_step;  // reset sweep: clear one row
    } t_ctl_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic in_flush;
        logic scan_last;
        logic clr_last;
        logic out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

// File: rtl/set_assoc_lru_cache_model_core.sv
`default_nettype none

// Set-associative LRU cache model core.
// Input stream: s_axis_tuser carries the access kind (instruction load,
// data load, data store, flush), s_axis_tdata the byte address. One result
// item on the master stream per input item: hit, replaced, fetched words
// and copy-back word counts on the instruction and data sides.
// Configuration: i_cfg_we with i_cfg_addr/i_cfg_wdata, to be written by the
// user only while idle; the block does not enforce this. A load or store
// reads its set from the row memory on acceptance, then compares, chooses a
// victim and writes back tags and ages; no new item is taken meanwhile.
// A flush walks every set in use, one memory row per cycle (both caches
// counted when split). After reset the block sweeps all 2*2^floor(log2 MAX_SETS)
// rows to clear valid, dirty and age fields (2048 rows by default);
// s_axis_tready stays low during the sweep. A result waits in the output
// register while m_axis_tready is low; no new item is taken until it can be
// replaced.
module set_assoc_lru_cache_model_core
    import sacl_pkg::*;
#(
    parameter int MAX_SETS  = DEF_MAX_SETS,
    parameter int MAX_WAYS  = DEF_MAX_WAYS,
    parameter int ADDR_BITS = DEF_ADDR_BITS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [ADDR_W-1:0]     s_axis_tdata,  // addr
    input  wire logic [OP_W-1:0]       s_axis_tuser,  // op
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // hit, replaced, fetch_words, copyback_inst_words, copyback_data_words
    output logic [OUT_W-1:0]           m_axis_tdata
);

    t_ctl_cmd w_cmd;
    t_dp_sts  w_sts;

    sacl_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .i_sts         (w_sts),
        .o_cmd         (w_cmd)
    );

    sacl_dpath #(
        .MAX_SETS  (MAX_SETS),
        .MAX_WAYS  (MAX_WAYS),
        .ADDR_BITS (ADDR_BITS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_op        (s_axis_tuser),
        .i_addr      (s_axis_tdata),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts)
    );

`ifndef SYNTHESIS
    a_look_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.lookup |=> m_axis_tvalid)
        else $error("lookup without a result");
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |-> (!m_axis_tvalid || m_axis_tready))
        else $error("item accepted while result stalled");
`endif

endmodule

`default_nettype wire

// File: rtl/sacl_ctrl.sv
`default_nettype none

module sacl_ctrl
    import sacl_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     s_axis_tvalid,
    output logic          s_axis_tready,
    input  wire t_dp_sts  i_sts,
    output t_ctl_cmd      o_cmd
);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_LOOK   = 3'd2;
    localparam logic [2:0] ST_SCAN   = 3'd3;
    localparam logic [2:0] ST_SDRAIN = 3'd4;
    localparam logic [2:0] ST_SOUT   = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       w_acc;

    assign s_axis_tready = (r_state == ST_IDLE) && i_sts.out_free;
    assign w_acc         = s_axis_tvalid && s_axis_tready;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_sts.clr_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (w_acc) begin
                    if (i_sts.in_flush) begin
                        o_cmd.scan_init = 1'b1;
                        n_state = ST_SCAN;
                    end else begin
                        o_cmd.accept = 1'b1;
                        n_state = ST_LOOK;
                    end
                end
            end
            ST_LOOK: begin
                o_cmd.lookup = 1'b1;
                n_state = ST_IDLE;
            end
            ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_last) n_state = ST_SDRAIN;
            end
            ST_SDRAIN: n_state = ST_SOUT;
            ST_SOUT: begin
                o_cmd.scan_out = 1'b1;
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef SYNTHESIS
    a_busy_after_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> !s_axis_tready)
        else $error("item accepted while previous one in work");
    a_scan_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SDRAIN) |=> o_cmd.scan_out)
        else $error("flush result not loaded after walk");
`endif

endmodule

`default_nettype wire

// File: rtl/sacl_dpath.sv
`default_nettype none

module sacl_dpath
    import sacl_pkg::*;
#(
    parameter int MAX_SETS  = DEF_MAX_SETS,
    parameter int MAX_WAYS  = DEF_MAX_WAYS,
    parameter int ADDR_BITS = DEF_ADDR_BITS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  wire logic [OP_W-1:0]       i_op,
    input  wire logic [ADDR_W-1:0]     i_addr,
    input  wire logic                  i_out_ready,
    output logic                       o_out_valid,
    output logic [OUT_W-1:0]           o_out_data,
    input  wire t_ctl_cmd              i_cmd,
    output t_dp_sts                    o_sts
);

    localparam int SLM     = $clog2(MAX_SETS + 1) - 1;
    localparam int SW      = (SLM < 1) ? 1 : SLM;
    localparam int RW      = SW + 1;
    localparam int ROWS    = 1 << RW;
    localparam int AGE_W   = (MAX_WAYS < 2) ? 1 : $clog2(MAX_WAYS);
    localparam int WI_W    = AGE_W;
    localparam int NW_W    = $clog2(MAX_WAYS + 1);
    localparam int WAY_W   = TAG_W + 2 + AGE_W;
    localparam int ROW_W   = WAY_W * MAX_WAYS;
    localparam int AGE_MAX = MAX_WAYS - 1;
    localparam logic [ADDR_W-1:0] AMASK = (ADDR_BITS >= ADDR_W) ? {ADDR_W{1'b1}} :
        ((32'd1 << ADDR_BITS) - 32'd1);

    // Configuration registers
    logic       r_split, r_wb, r_wa;
    logic [2:0] r_lb;
    logic [3:0] r_ls0, r_ls1, r_ways;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_split <= 1'b0;
            r_wb    <= 1'b1;
            r_wa    <= 1'b1;
            r_lb    <= 3'd4;
            r_ls0   <= 4'd6;
            r_ls1   <= 4'd6;
            r_ways  <= 4'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_SPLIT: r_split <= i_cfg_wdata[0];
                CFG_WB:    r_wb    <= i_cfg_wdata[0];
                CFG_WA:    r_wa    <= i_cfg_wdata[0];
                CFG_BLK:   r_lb    <= i_cfg_wdata[2:0];
                CFG_SETS0: r_ls0   <= i_cfg_wdata;
                CFG_SETS1: r_ls1   <= i_cfg_wdata;
                CFG_WAYS:  r_ways  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Effective geometry
    logic [2:0]          lb_eff;
    logic [3:0]          ls0_eff, ls1_eff;
    logic [NW_W:0]       nw;
    logic [MAX_WAYS-1:0] use_w;
    logic [FETCH_W-1:0]  words;

    always_comb begin
        lb_eff  = (r_lb < 3'd2) ? 3'd2 : r_lb;
        ls0_eff = ({1'b0, r_ls0} > 5'(SLM)) ? 4'(SLM) : r_ls0;
        ls1_eff = ({1'b0, r_ls1} > 5'(SLM)) ? 4'(SLM) : r_ls1;
        nw      = (r_ways == 4'd0) ? (NW_W+1)'(1) : (NW_W+1)'(r_ways);
        if (nw > (NW_W+1)'(MAX_WAYS)) nw = (NW_W+1)'(MAX_WAYS);
        for (int w = 0; w < MAX_WAYS; w++) use_w[w] = ((NW_W+1)'(w) < nw);
        words   = FETCH_W'(1) << (lb_eff - 3'd2);
    end

    // Incoming item address split
    logic                in_c;
    logic [3:0]          in_ls;
    logic [ADDR_W-1:0]   addr_m, set_full, set_msk, tag_full;
    logic [SW-1:0]       in_set;

    always_comb begin
        in_c     = r_split && (i_op != OP_ILOAD);
        in_ls    = in_c ? ls1_eff : ls0_eff;
        addr_m   = i_addr & AMASK;
        set_full = addr_m >> lb_eff;
        set_msk  = (32'd1 << in_ls) - 32'd1;
        in_set   = SW'(set_full & set_msk);
        tag_full = addr_m >> ({2'b0, lb_eff} + {1'b0, in_ls});
    end

    // Walk pointer: flush scan and reset sweep
    logic [RW-1:0] r_ptr;
    logic [3:0]    sc_ls;
    logic [SW-1:0] sc_mask;
    logic          sc_set_end;

    always_comb begin
        sc_ls      = r_ptr[RW-1] ? ls1_eff : ls0_eff;
        sc_mask    = SW'((32'd1 << sc_ls) - 32'd1);
        sc_set_end = (r_ptr[SW-1:0] == sc_mask);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr <= '0;
        end else if (i_cmd.scan_init) begin
            r_ptr <= '0;
        end else if (i_cmd.clear_step) begin
            r_ptr <= r_ptr + RW'(1);
        end else if (i_cmd.scan_step) begin
            r_ptr <= sc_set_end ? {1'b1, {SW{1'b0}}} : r_ptr + RW'(1);
        end
    end

    // Set memory, one row per set, all ways side by side
    logic [ROW_W-1:0] mem [ROWS];
    logic [ROW_W-1:0] r_rd;
    logic [ROW_W-1:0] wr_row;
    logic [RW-1:0]    rd_addr;
    logic [RW-1:0]    r_row;
    logic             we;
    logic [RW-1:0]    wr_addr;
    logic [ROW_W-1:0] wr_data;

    assign rd_addr = i_cmd.accept ? {in_c, in_set} : r_ptr;
    assign we      = i_cmd.lookup || i_cmd.clear_step;
    assign wr_addr = i_cmd.clear_step ? r_ptr : r_row;
    assign wr_data = i_cmd.clear_step ? '0 : wr_row;

    always_ff @(posedge i_clk) begin
        if (we) mem[wr_addr] <= wr_data;
        if (i_cmd.accept || i_cmd.scan_step) r_rd <= mem[rd_addr];
    end

    // Latched item
    logic [OP_W-1:0]  r_op;
    logic [TAG_W-1:0] r_tag;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op  <= i_op;
            r_tag <= tag_full[TAG_W-1:0];
            r_row <= {in_c, in_set};
        end
    end

    // Set lookup and update
    logic [TAG_W-1:0] tg [MAX_WAYS];
    logic [AGE_W-1:0] ag [MAX_WAYS];
    logic [AGE_W-1:0] nag [MAX_WAYS];
    logic [MAX_WAYS-1:0] vl, dt, nvl, ndt;
    logic [TAG_W-1:0] ntg [MAX_WAYS];
    logic             l_store, hit, bypass, fill, fnd_inv, repl;
    logic [WI_W-1:0]  hway, iway, oway, way;
    logic [AGE_W-1:0] best;
    logic [AGE_W:0]   limit;
    logic [FETCH_W-1:0] l_fetch;
    logic [CB_W-1:0]  l_cbi, l_cbd;

    always_comb begin
        for (int w = 0; w < MAX_WAYS; w++) begin
            tg[w] = r_rd[w*WAY_W +: TAG_W];
            vl[w] = r_rd[w*WAY_W + TAG_W];
            dt[w] = r_rd[w*WAY_W + TAG_W + 1];
            ag[w] = r_rd[w*WAY_W + TAG_W + 2 +: AGE_W];
        end
        l_store = (r_op == OP_STORE);
        hit = 1'b0;
        hway = '0;
        fnd_inv = 1'b0;
        iway = '0;
        best = '0;
        oway = '0;
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (!hit && use_w[w] && vl[w] && tg[w] == r_tag) begin
                hit = 1'b1;
                hway = WI_W'(w);
            end
            if (!fnd_inv && use_w[w] && !vl[w]) begin
                fnd_inv = 1'b1;
                iway = WI_W'(w);
            end
            if (use_w[w] && ag[w] > best) begin
                best = ag[w];
                oway = WI_W'(w);
            end
        end
        bypass  = !hit && l_store && !r_wa;
        fill    = !hit && !bypass;
        repl    = fill && !fnd_inv;
        way     = hit ? hway : (fnd_inv ? iway : oway);
        limit   = hit ? {1'b0, ag[hway]} :
                  (fnd_inv ? {1'b1, {AGE_W{1'b0}}} : {1'b0, best});
        l_fetch = fill ? words : '0;
        l_cbi   = '0;
        // a bypassed store always writes its word through
        l_cbd   = (l_store && (!r_wb || bypass)) ? CB_W'(1) : '0;
        if (repl && dt[oway]) begin
            if (r_op == OP_ILOAD) l_cbi = CB_W'(words);
            else l_cbd = l_cbd + CB_W'(words);
        end
        // Age, tag and mark update
        for (int w = 0; w < MAX_WAYS; w++) begin
            ntg[w] = tg[w];
            nvl[w] = vl[w];
            ndt[w] = dt[w];
            nag[w] = ag[w];
            if (!bypass) begin
                if (WI_W'(w) == way) begin
                    nag[w] = '0;
                    if (fill) begin
                        ntg[w] = r_tag;
                        nvl[w] = 1'b1;
                        ndt[w] = l_store && r_wb;
                    end else if (l_store && r_wb) begin
                        ndt[w] = 1'b1;
                    end
                end else if (use_w[w] && vl[w] && {1'b0, ag[w]} < limit
                             && ag[w] < AGE_W'(AGE_MAX)) begin
                    nag[w] = ag[w] + AGE_W'(1);
                end
            end
        end
        for (int w = 0; w < MAX_WAYS; w++) begin
            wr_row[w*WAY_W +: WAY_W] = {nag[w], ndt[w], nvl[w], ntg[w]};
        end
    end

    // Flush counting, one set per cycle
    logic            r_sv, r_sc;
    logic [CB_W-1:0] r_acc_i, r_acc_d;
    logic [NW_W-1:0] dcnt;
    logic [CB_W-1:0] dadd;

    always_comb begin
        dcnt = '0;
        for (int w = 0; w < MAX_WAYS; w++) begin
            dcnt = dcnt + NW_W'(use_w[w] && vl[w] && dt[w]);
        end
        dadd = CB_W'(dcnt) << (lb_eff - 3'd2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv <= 1'b0;
        end else begin
            r_sv <= i_cmd.scan_step;
        end
        if (i_cmd.scan_step) r_sc <= r_ptr[RW-1];
        if (i_cmd.scan_init) begin
            r_acc_i <= '0;
            r_acc_d <= '0;
        end else if (r_sv) begin
            if (r_sc) r_acc_d <= r_acc_d + dadd;
            else r_acc_i <= r_acc_i + dadd;
        end
    end

    // Result register
    logic               r_ovalid, r_hit, r_rep;
    logic [FETCH_W-1:0] r_fetch;
    logic [CB_W-1:0]    r_cbi, r_cbd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.lookup || i_cmd.scan_out) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
        if (i_cmd.lookup) begin
            r_hit   <= hit;
            r_rep   <= repl;
            r_fetch <= l_fetch;
            r_cbi   <= l_cbi;
            r_cbd   <= l_cbd;
        end else if (i_cmd.scan_out) begin
            r_hit   <= 1'b0;
            r_rep   <= 1'b0;
            r_fetch <= '0;
            r_cbi   <= r_acc_i;
            r_cbd   <= r_acc_d;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = {r_cbd, r_cbi, r_fetch, r_rep, r_hit};

    always_comb begin
        o_sts.in_flush  = (i_op == OP_FLUSH);
        o_sts.scan_last = sc_set_end && (r_ptr[RW-1] == r_split);
        o_sts.clr_last  = &r_ptr;
        o_sts.out_free  = !r_ovalid || i_out_ready;
    end

`ifndef SYNTHESIS
    a_one_way: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.lookup |-> !(hit && repl))
        else $error("hit and replacement in one access");
    a_scan_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv |-> $past(i_cmd.scan_step))
        else $error("flush count without a set read");
`endif

endmodule

`default_nettype wire
